// File: rtl/core/pfsa_pkg.sv
// Shared constants, codes and controller/datapath interface types for the page allocator.
package pfsa_pkg;

   localparam int STACK_DEPTH = 4096;
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int TOP_W       = $clog2(STACK_DEPTH + 1);
   localparam int PAGE_SHIFT  = 12;
   localparam int ADDR_W      = 32;
   localparam int FRAME_W     = ADDR_W - PAGE_SHIFT;
   localparam int COUNT_W     = 21;
   localparam int ACTION_W    = 2;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 1;

   localparam int REQ_DATA_W  = 3 * ADDR_W;
   localparam int RSP_FIELD_W = ADDR_W + 2 * COUNT_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   localparam logic [ADDR_W-1:0]    USABLE_BASE   = 32'h0010_0000;
   localparam logic [ADDR_W-1:0]    OFFSET_MASK   = 32'h0000_0FFF;
   localparam logic [ADDR_W-1:0]    USABLE_TYPE   = 32'h0000_0001;
   localparam logic [ADDR_W-1:0]    MAX_ADDR_INIT = 32'h2000_0000;
   localparam logic [COUNT_W-1:0]   TOTAL_MAX     = 21'd1048576;
   localparam logic [TOP_W-1:0]     TOP_FULL      = TOP_W'(STACK_DEPTH);

   localparam logic [ACTION_W-1:0]  ACT_REGION = 2'd0;
   localparam logic [ACTION_W-1:0]  ACT_ALLOC  = 2'd1;
   localparam logic [ACTION_W-1:0]  ACT_FREE   = 2'd2;

   localparam logic [STATUS_W-1:0]  ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0]  ST_OOM        = 2'd1;
   localparam logic [STATUS_W-1:0]  ST_FULL       = 2'd2;
   localparam logic [STATUS_W-1:0]  ST_MISALIGNED = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ADDR    = 1'd1;

   typedef struct packed {
      logic                capture;
      logic                push_page;
      logic                push_free;
      logic                pop;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                load_rsp;
   } cmd_type;

   typedef struct packed {
      logic fill_more;
      logic full;
      logic empty;
      logic misaligned;
      logic rsp_free;
   } sts_type;

endpackage

// File: rtl/core/pfsa_ctrl.sv
// Controller state machine sequencing region fills, pops, pushes and result hand-off.
module pfsa_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pfsa_pkg::ACTION_W-1:0]    req_action,
   input  pfsa_pkg::sts_type                sts,
   output pfsa_pkg::cmd_type                cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FILL,
      S_POP,
      S_FREE,
      S_RESP
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.status = pfsa_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               case (req_action)
                  pfsa_pkg::ACT_REGION: state_in = S_FILL;
                  pfsa_pkg::ACT_ALLOC:  state_in = S_POP;
                  pfsa_pkg::ACT_FREE:   state_in = S_FREE;
                  default:              state_in = S_RESP;
               endcase
            end
         end
         S_FILL: begin
            if (!sts.fill_more) begin
               state_in = S_RESP;
            end else if (sts.full) begin
               cmd.set_status = 1'b1;
               cmd.status     = pfsa_pkg::ST_FULL;
               state_in       = S_RESP;
            end else begin
               cmd.push_page = 1'b1;
            end
         end
         S_POP: begin
            if (sts.empty) begin
               cmd.set_status = 1'b1;
               cmd.status     = pfsa_pkg::ST_OOM;
            end else begin
               cmd.pop = 1'b1;
            end
            state_in = S_RESP;
         end
         S_FREE: begin
            if (sts.full) begin
               cmd.set_status = 1'b1;
               cmd.status     = pfsa_pkg::ST_FULL;
            end else if (sts.misaligned) begin
               cmd.set_status = 1'b1;
               cmd.status     = pfsa_pkg::ST_MISALIGNED;
            end else begin
               cmd.push_free = 1'b1;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// File: rtl/core/pfsa_dp.sv
// Datapath: stack memory, stack pointer, page counters, config registers and result register.
module pfsa_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  pfsa_pkg::cmd_type                   cmd,
   output pfsa_pkg::sts_type                   sts,
   input  logic [pfsa_pkg::ADDR_W-1:0]         in_address,
   input  logic [pfsa_pkg::ADDR_W-1:0]         in_length,
   input  logic [pfsa_pkg::ADDR_W-1:0]         in_type,
   input  logic                                csr_we,
   input  logic [pfsa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pfsa_pkg::ADDR_W-1:0]         csr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pfsa_pkg::ADDR_W-1:0]         rsp_page,
   output logic [pfsa_pkg::STATUS_W-1:0]       rsp_status,
   output logic [pfsa_pkg::COUNT_W-1:0]        rsp_free_count,
   output logic [pfsa_pkg::COUNT_W-1:0]        rsp_pages_added
);

   logic [pfsa_pkg::FRAME_W-1:0]  stack_mem [pfsa_pkg::STACK_DEPTH];

   logic [pfsa_pkg::TOP_W-1:0]    top_ff, top_in;
   logic [pfsa_pkg::COUNT_W-1:0]  total_ff, total_in;
   logic [pfsa_pkg::ADDR_W-1:0]   kernel_size_ff, max_addr_ff;
   logic                          rsp_valid_ff;

   logic [pfsa_pkg::ADDR_W-1:0]   addr_ff, page_ff, end_ff;
   logic                          region_ok_ff;
   logic [pfsa_pkg::STATUS_W-1:0] res_status_ff;
   logic                          popped_ff;
   logic [pfsa_pkg::FRAME_W-1:0]  rd_ff;

   logic [pfsa_pkg::ADDR_W-1:0]   rsp_page_ff;
   logic [pfsa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [pfsa_pkg::COUNT_W-1:0]  rsp_free_ff, rsp_added_ff;

   logic [pfsa_pkg::ADDR_W-1:0]   start_in, end_in;
   logic [pfsa_pkg::TOP_W-1:0]    top_dec;
   logic                          mem_we;
   logic [pfsa_pkg::FRAME_W-1:0]  wr_frame;

   assign start_in = (in_address + kernel_size_ff + pfsa_pkg::OFFSET_MASK) & ~pfsa_pkg::OFFSET_MASK;
   assign end_in   = (in_address + in_length) & ~pfsa_pkg::OFFSET_MASK;
   assign top_dec  = top_ff - 1'b1;

   assign sts.fill_more  = region_ok_ff && (page_ff < end_ff) && (page_ff < max_addr_ff);
   assign sts.full       = (top_ff == pfsa_pkg::TOP_FULL);
   assign sts.empty      = (top_ff == '0);
   assign sts.misaligned = |(addr_ff & pfsa_pkg::OFFSET_MASK);
   assign sts.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign mem_we   = cmd.push_page || cmd.push_free;
   assign wr_frame = cmd.push_page ? page_ff[pfsa_pkg::ADDR_W-1:pfsa_pkg::PAGE_SHIFT]
                                   : addr_ff[pfsa_pkg::ADDR_W-1:pfsa_pkg::PAGE_SHIFT];

   always_comb begin
      top_in   = top_ff;
      total_in = total_ff;
      if (mem_we) begin
         top_in = top_ff + 1'b1;
      end else if (cmd.pop) begin
         top_in = top_dec;
      end
      if (cmd.push_page && total_ff != pfsa_pkg::TOTAL_MAX) begin
         total_in = total_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff         <= '0;
         total_ff       <= '0;
         kernel_size_ff <= '0;
         max_addr_ff    <= pfsa_pkg::MAX_ADDR_INIT;
         rsp_valid_ff   <= 1'b0;
      end else begin
         top_ff   <= top_in;
         total_ff <= total_in;
         if (csr_we) begin
            case (csr_index)
               pfsa_pkg::CSR_KERNEL_SIZE: kernel_size_ff <= csr_data;
               pfsa_pkg::CSR_MAX_ADDR:    max_addr_ff    <= csr_data;
               default: ;
            endcase
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff       <= in_address;
         page_ff       <= start_in;
         end_ff        <= end_in;
         region_ok_ff  <= (in_type == pfsa_pkg::USABLE_TYPE) && (in_address == pfsa_pkg::USABLE_BASE);
         res_status_ff <= pfsa_pkg::ST_OK;
         popped_ff     <= 1'b0;
      end else begin
         if (cmd.push_page) begin
            page_ff <= page_ff + (pfsa_pkg::ADDR_W'(1) << pfsa_pkg::PAGE_SHIFT);
         end
         if (cmd.set_status) begin
            res_status_ff <= cmd.status;
         end
         if (cmd.pop) begin
            popped_ff <= 1'b1;
         end
      end
      if (cmd.load_rsp) begin
         rsp_page_ff   <= popped_ff ? {rd_ff, {pfsa_pkg::PAGE_SHIFT{1'b0}}} : '0;
         rsp_status_ff <= res_status_ff;
         rsp_free_ff   <= pfsa_pkg::COUNT_W'(top_ff);
         rsp_added_ff  <= total_ff;
      end
   end

   // stack memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[top_ff[pfsa_pkg::IDX_W-1:0]] <= wr_frame;
      end
      if (cmd.pop) begin
         rd_ff <= stack_mem[top_dec[pfsa_pkg::IDX_W-1:0]];
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_page        = rsp_page_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_free_count  = rsp_free_ff;
   assign rsp_pages_added = rsp_added_ff;

endmodule

// File: rtl/core/page_frame_stack_allocator.sv
// Top level of the free page stack allocator: controller plus datapath.
// Sequencing: the controller steps one stack memory access per cycle; a region item pushes
// its pages in turn, alloc pops and free pushes at most one page, then the result is loaded.
// A new item is taken only after the last result is loaded; it is taken while a result waits.
// Reset: synchronous, active high; empties the stack, clears page total and kernel_size,
// sets max_phys_addr to 0x20000000. Stack memory contents are not cleared.
module page_frame_stack_allocator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pfsa_pkg::REQ_DATA_W-1:0]      req_tdata,  // address, region_length, region_type
   input  logic [pfsa_pkg::ACTION_W-1:0]        req_tuser,  // action
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [pfsa_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // page_address, free_count, pages_added
   output logic [pfsa_pkg::STATUS_W-1:0]        rsp_tuser,  // status
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pfsa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pfsa_pkg::ADDR_W-1:0]          csr_data
);

   pfsa_pkg::cmd_type              cmd;
   pfsa_pkg::sts_type              sts;
   logic [pfsa_pkg::ADDR_W-1:0]    rsp_page;
   logic [pfsa_pkg::COUNT_W-1:0]   rsp_free_count, rsp_pages_added;

   assign csr_ready = 1'b1;

   pfsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   pfsa_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .in_address      (req_tdata[pfsa_pkg::ADDR_W-1:0]),
      .in_length       (req_tdata[2*pfsa_pkg::ADDR_W-1:pfsa_pkg::ADDR_W]),
      .in_type         (req_tdata[3*pfsa_pkg::ADDR_W-1:2*pfsa_pkg::ADDR_W]),
      .csr_we          (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_page        (rsp_page),
      .rsp_status      (rsp_tuser),
      .rsp_free_count  (rsp_free_count),
      .rsp_pages_added (rsp_pages_added)
   );

   assign rsp_tdata = {{pfsa_pkg::RSP_PAD_W{1'b0}}, rsp_pages_added, rsp_free_count, rsp_page};

endmodule

// File: bench/page_frame_stack_allocator_test.sv
// Self-checking testbench for the page frame stack allocator: directed and random items.
`timescale 1ns / 100ps

module page_frame_stack_allocator_test;

   localparam logic [pfsa_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;

   typedef struct packed {
      logic [pfsa_pkg::ADDR_W-1:0]   page_address;
      logic [pfsa_pkg::STATUS_W-1:0] status;
      logic [pfsa_pkg::COUNT_W-1:0]  free_count;
      logic [pfsa_pkg::COUNT_W-1:0]  pages_added;
   } alloc_result_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [pfsa_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [pfsa_pkg::ACTION_W-1:0]   req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [pfsa_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [pfsa_pkg::STATUS_W-1:0]   rsp_tuser;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [pfsa_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [pfsa_pkg::ADDR_W-1:0]     csr_data   = '0;

   // predicted allocator state
   logic [pfsa_pkg::FRAME_W-1:0] frame_stack [pfsa_pkg::STACK_DEPTH];
   int                           free_pages        = 0;
   logic [pfsa_pkg::COUNT_W-1:0] region_page_total = '0;
   logic [pfsa_pkg::ADDR_W-1:0]  kernel_size_reg   = '0;
   logic [pfsa_pkg::ADDR_W-1:0]  max_addr_reg      = pfsa_pkg::MAX_ADDR_INIT;

   alloc_result_type expected_results[$];
   int               mismatch_count    = 0;
   int               send_idle_pct     = 13;
   int               recv_idle_pct     = 47;
   int               recv_hold_request = 0;

   page_frame_stack_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial forever #2 clock = ~clock;

   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic alloc_result_type predict_step(
         input logic [pfsa_pkg::ACTION_W-1:0] act, input logic [pfsa_pkg::ADDR_W-1:0] addr,
         input logic [pfsa_pkg::ADDR_W-1:0] len, input logic [pfsa_pkg::ADDR_W-1:0] rtype);
      alloc_result_type r;
      logic [pfsa_pkg::ADDR_W-1:0] page;
      logic [pfsa_pkg::ADDR_W-1:0] last;
      r = '0;
      r.status = pfsa_pkg::ST_OK;
      case (act)
         pfsa_pkg::ACT_REGION: begin
            if (rtype == pfsa_pkg::USABLE_TYPE && addr == pfsa_pkg::USABLE_BASE) begin
               page = (addr + kernel_size_reg + pfsa_pkg::OFFSET_MASK)
                      & ~pfsa_pkg::OFFSET_MASK;
               last = (addr + len) & ~pfsa_pkg::OFFSET_MASK;
               while (page < last && page < max_addr_reg && r.status == pfsa_pkg::ST_OK) begin
                  if (free_pages == pfsa_pkg::STACK_DEPTH) begin
                     r.status = pfsa_pkg::ST_FULL;
                  end else begin
                     frame_stack[free_pages] = page[pfsa_pkg::ADDR_W-1:pfsa_pkg::PAGE_SHIFT];
                     free_pages++;
                     if (region_page_total < pfsa_pkg::TOTAL_MAX) region_page_total++;
                     page = page + (pfsa_pkg::ADDR_W'(1) << pfsa_pkg::PAGE_SHIFT);
                  end
               end
            end
         end
         pfsa_pkg::ACT_ALLOC: begin
            if (free_pages == 0) begin
               r.status = pfsa_pkg::ST_OOM;
            end else begin
               free_pages--;
               r.page_address = pfsa_pkg::ADDR_W'(frame_stack[free_pages])
                                << pfsa_pkg::PAGE_SHIFT;
            end
         end
         pfsa_pkg::ACT_FREE: begin
            if (free_pages == pfsa_pkg::STACK_DEPTH) begin
               r.status = pfsa_pkg::ST_FULL;
            end else if ((addr & pfsa_pkg::OFFSET_MASK) != '0) begin
               r.status = pfsa_pkg::ST_MISALIGNED;
            end else begin
               frame_stack[free_pages] = addr[pfsa_pkg::ADDR_W-1:pfsa_pkg::PAGE_SHIFT];
               free_pages++;
            end
         end
         default: ;
      endcase
      r.free_count  = pfsa_pkg::COUNT_W'(free_pages);
      r.pages_added = region_page_total;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [pfsa_pkg::ADDR_W-1:0] got,
         input logic [pfsa_pkg::ADDR_W-1:0] want);
      $display("%0t: %s got %0h, expected %0h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_results
      alloc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected item, page_address",
                            rsp_tdata[pfsa_pkg::ADDR_W-1:0], '0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[pfsa_pkg::ADDR_W-1:0] !== want.page_address)
               report_mismatch("page_address", rsp_tdata[pfsa_pkg::ADDR_W-1:0],
                               want.page_address);
            if (rsp_tuser !== want.status)
               report_mismatch("status", pfsa_pkg::ADDR_W'(rsp_tuser),
                               pfsa_pkg::ADDR_W'(want.status));
            if (rsp_tdata[pfsa_pkg::ADDR_W +: pfsa_pkg::COUNT_W] !== want.free_count)
               report_mismatch("free_count",
                               pfsa_pkg::ADDR_W'(rsp_tdata[pfsa_pkg::ADDR_W +: pfsa_pkg::COUNT_W]),
                               pfsa_pkg::ADDR_W'(want.free_count));
            if (rsp_tdata[pfsa_pkg::ADDR_W+pfsa_pkg::COUNT_W +: pfsa_pkg::COUNT_W]
                !== want.pages_added)
               report_mismatch("pages_added",
                               pfsa_pkg::ADDR_W'(rsp_tdata[pfsa_pkg::ADDR_W+pfsa_pkg::COUNT_W
                                                           +: pfsa_pkg::COUNT_W]),
                               pfsa_pkg::ADDR_W'(want.pages_added));
         end
      end
   end

   // receiver: random stalls, plus long hold-offs on request
   initial begin : receiver
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (recv_hold_request != 0) begin
            hold = recv_hold_request;
            recv_hold_request = 0;
         end
         if (hold != 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic offer_request(input logic [pfsa_pkg::ACTION_W-1:0] act,
         input logic [pfsa_pkg::ADDR_W-1:0] addr, input logic [pfsa_pkg::ADDR_W-1:0] len,
         input logic [pfsa_pkg::ADDR_W-1:0] rtype);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {rtype, len, addr};
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(predict_step(act, addr, len, rtype));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [pfsa_pkg::CSR_IDX_W-1:0] idx,
         input logic [pfsa_pkg::ADDR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == pfsa_pkg::CSR_KERNEL_SIZE) kernel_size_reg = value;
      else max_addr_reg = value;
   endtask

   task automatic configure(input logic [pfsa_pkg::ADDR_W-1:0] ks,
         input logic [pfsa_pkg::ADDR_W-1:0] max_addr);
      wait_drained();
      write_register(pfsa_pkg::CSR_KERNEL_SIZE, ks);
      write_register(pfsa_pkg::CSR_MAX_ADDR, max_addr);
      csr_valid <= 1'b0;
   endtask

   task automatic test_empty_stack_codes();
      offer_request(pfsa_pkg::ACT_ALLOC, '0, '0, '0);
      offer_request(ACT_NONE, '1, '1, '1);
      offer_request(pfsa_pkg::ACT_FREE, 32'h0000_0001, '0, '0);
      offer_request(pfsa_pkg::ACT_FREE, 32'hFFFF_FFFF, '0, '0);
      offer_request(pfsa_pkg::ACT_FREE, 32'hFFFF_F000, '0, '0);
      offer_request(pfsa_pkg::ACT_FREE, 32'h0000_0000, '0, '0);
      offer_request(pfsa_pkg::ACT_ALLOC, '0, '0, '0);
      offer_request(pfsa_pkg::ACT_ALLOC, '0, '0, '0);
      offer_request(pfsa_pkg::ACT_ALLOC, '0, '0, '0);
   endtask

   task automatic test_region_entries();
      offer_request(pfsa_pkg::ACT_REGION, pfsa_pkg::USABLE_BASE, 32'h0001_0000, 32'h0000_0000);
      offer_request(pfsa_pkg::ACT_REGION, pfsa_pkg::USABLE_BASE, 32'h0001_0000, 32'hFFFF_FFFF);
      offer_request(pfsa_pkg::ACT_REGION, pfsa_pkg::USABLE_BASE + 1, 32'h0001_0000,
                    pfsa_pkg::USABLE_TYPE);
      offer_request(pfsa_pkg::ACT_REGION, '0, 32'hFFFF_FFFF, pfsa_pkg::USABLE_TYPE);
      offer_request(pfsa_pkg::ACT_REGION, pfsa_pkg::USABLE_BASE, '0, pfsa_pkg::USABLE_TYPE);
      offer_request(pfsa_pkg::ACT_REGION, pfsa_pkg::USABLE_BASE, 32'h0000_5000,
                    pfsa_pkg::USABLE_TYPE);
      // odd kernel size, fill capped by max_phys_addr
      configure(32'h0000_1801, 32'h0010_8000);
      offer_request(pfsa_pkg::ACT_REGION, pfsa_pkg::USABLE_BASE, 32'h0001_0000,
                    pfsa_pkg::USABLE_TYPE);
      // kernel size wraps the start back onto the base
      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer_request(pfsa_pkg::ACT_REGION, pfsa_pkg::USABLE_BASE, 32'h0000_3FFF,
                    pfsa_pkg::USABLE_TYPE);
      repeat (3) offer_request(pfsa_pkg::ACT_ALLOC, '0, '0, '0);
   endtask

   task automatic test_stack_full_and_drain();
      configure(32'h0000_0000, 32'hFFFF_FFFF);
      offer_request(pfsa_pkg::ACT_REGION, pfsa_pkg::USABLE_BASE, 32'h1000_0000,
                    pfsa_pkg::USABLE_TYPE);
      offer_request(pfsa_pkg::ACT_FREE, 32'h0000_1000, '0, '0);
      offer_request(pfsa_pkg::ACT_FREE, 32'h0000_1001, '0, '0);
      offer_request(pfsa_pkg::ACT_REGION, pfsa_pkg::USABLE_BASE, 32'h1000_0000,
                    pfsa_pkg::USABLE_TYPE);
      offer_request(pfsa_pkg::ACT_ALLOC, '0, '0, '0);
      offer_request(pfsa_pkg::ACT_FREE, 32'h0000_3000, '0, '0);
      // back-pressure: results held off while allocs keep coming
      recv_hold_request = 400;
      repeat (41) offer_request(pfsa_pkg::ACT_ALLOC, '0, '0, '0);
   endtask

   task automatic test_random_mix(input int count);
      logic [pfsa_pkg::ADDR_W-1:0]   addr;
      logic [pfsa_pkg::ADDR_W-1:0]   len;
      logic [pfsa_pkg::ADDR_W-1:0]   rtype;
      logic [pfsa_pkg::ADDR_W-1:0]   start;
      logic [pfsa_pkg::ACTION_W-1:0] act;
      int unsigned                   pick;
      repeat (count) begin
         addr  = $urandom;
         len   = $urandom;
         rtype = $urandom;
         pick  = $urandom_range(99);
         if (free_pages > 3000 && $urandom_range(1) == 0) pick = 40;
         if (pick < 18) begin
            act   = pfsa_pkg::ACT_REGION;
            addr  = pfsa_pkg::USABLE_BASE;
            rtype = pfsa_pkg::USABLE_TYPE;
            if ($urandom_range(39) != 0) begin
               start = (pfsa_pkg::USABLE_BASE + kernel_size_reg + pfsa_pkg::OFFSET_MASK)
                       & ~pfsa_pkg::OFFSET_MASK;
               len = start - pfsa_pkg::USABLE_BASE
                     + ($urandom_range(24) << pfsa_pkg::PAGE_SHIFT) + $urandom_range(4095);
            end
         end else if (pick < 26) begin
            act = pfsa_pkg::ACT_REGION;
            case ($urandom_range(2))
               0: addr = pfsa_pkg::USABLE_BASE;
               1: rtype = pfsa_pkg::USABLE_TYPE;
               default: begin
                  addr  = pfsa_pkg::USABLE_BASE;
                  rtype = $urandom_range(5);
               end
            endcase
         end else if (pick < 58) begin
            act = pfsa_pkg::ACT_ALLOC;
         end else if (pick < 95) begin
            act = pfsa_pkg::ACT_FREE;
            if ($urandom_range(6) != 0) addr = addr & ~pfsa_pkg::OFFSET_MASK;
         end else begin
            act = ACT_NONE;
         end
         offer_request(act, addr, len, rtype);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_empty_stack_codes();
      test_region_entries();
      test_stack_full_and_drain();
      configure($urandom_range(32'h5000), 32'hFFFF_FFFF);
      test_random_mix(225);
      send_idle_pct = 47;
      recv_idle_pct = 13;
      configure(32'hFFFF_FFFF, 32'h0018_0000);
      test_random_mix(115);
      configure($urandom, 32'h0000_0000);
      test_random_mix(115);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(32'hFFFF_F001, $urandom);
      test_random_mix(225);
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
